FILE: hw/rtl/csid_pkg.sv
// Package for the checked signed integer divider.
// Holds the stream field widths and the operand width mode codes.
// No dependencies.
package csid_pkg;

  localparam int unsigned FIELD_W    = 64;
  localparam int unsigned IN_TDATA_W = 2 * FIELD_W;
  localparam int unsigned OUT_DATA_W = FIELD_W;
  localparam int unsigned MODE_W     = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_8  = 2'd0,
    MODE_16 = 2'd1,
    MODE_32 = 2'd2,
    MODE_64 = 2'd3
  } mode_e;

endpackage

FILE: hw/rtl/checked_signed_int_divider.sv
// Checked signed integer divider, truncating toward zero, fully pipelined.
// Depends on csid_pkg for field widths and the width mode codes.
//
//   channel   dir  fields (lowest bit up)                  handshake
//   s_axis    in   tdata: dividend[63:0], divisor[127:64]  s_axis_tvalid/tready
//   m_axis    out  tdata: quotient[63:0]; tuser: ok        m_axis_tvalid/tready
//   cfg       in   cfg_data_i: width_mode[1:0]             cfg_valid_i/cfg_ready_o
//
// One item per cycle sustained while the output is not stalled; the stages are one operand
// stage, one restoring-division stage per quotient bit, one output stage.
// Each division stage holds one (DATA_WIDTH+1)-bit compare and subtract.
// Reset clears all valid bits and sets width_mode to 64 bits.
// A stalled output holds the whole pipeline; nothing is dropped or repeated.
module checked_signed_int_divider #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [csid_pkg::MODE_W-1:0]     cfg_data_i,     // width_mode
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [csid_pkg::IN_TDATA_W-1:0] s_axis_tdata,   // dividend, divisor
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [csid_pkg::OUT_DATA_W-1:0] m_axis_tdata,   // quotient
  output logic                            m_axis_tuser    // ok
);

  import csid_pkg::*;

  localparam int unsigned DW = DATA_WIDTH;
  localparam int unsigned W0 = (8  < DW) ? 8  : DW;
  localparam int unsigned W1 = (16 < DW) ? 16 : DW;
  localparam int unsigned W2 = (32 < DW) ? 32 : DW;
  localparam int unsigned W3 = (64 < DW) ? 64 : DW;
  localparam logic [DW-1:0] MNEG0 = {DW{1'b1}} << (W0 - 1);
  localparam logic [DW-1:0] MNEG1 = {DW{1'b1}} << (W1 - 1);
  localparam logic [DW-1:0] MNEG2 = {DW{1'b1}} << (W2 - 1);
  localparam logic [DW-1:0] MNEG3 = {DW{1'b1}} << (W3 - 1);

  mode_e mode_q;

  logic          adv;
  logic [DW-1:0] a_raw, b_raw, a_ext, b_ext, mneg;
  logic          a_sgn, b_sgn;

  logic          v_q    [DW+1];
  logic          v_d    [DW+1];
  logic [DW-1:0] rem_q  [DW+1];
  logic [DW-1:0] rem_d  [DW+1];
  logic [DW-1:0] num_q  [DW+1];
  logic [DW-1:0] num_d  [DW+1];
  logic [DW-1:0] den_q  [DW+1];
  logic [DW-1:0] den_d  [DW+1];
  logic          neg_q  [DW+1];
  logic          neg_d  [DW+1];
  logic          fail_q [DW+1];
  logic          fail_d [DW+1];

  logic [DW:0]          trial [DW];
  logic                 ge    [DW];
  logic signed [DW-1:0] q_sgn;

  logic                  out_valid_q;
  logic [OUT_DATA_W-1:0] quot_q, quot_d;
  logic                  ok_q, ok_d;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = quot_q;
  assign m_axis_tuser  = ok_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_64;
    end else if (cfg_valid_i) begin
      mode_q <= mode_e'(cfg_data_i);
    end
  end

  // Operand stage: sign-extend from the selected width, check, take magnitudes
  always_comb begin
    a_raw = s_axis_tdata[DW-1:0];
    b_raw = s_axis_tdata[FIELD_W +: DW];
    a_ext = '0;
    b_ext = '0;
    mneg  = MNEG3;
    unique case (mode_q)
      MODE_8: begin
        mneg = MNEG0;
        for (int i = 0; i < DW; i++) begin
          a_ext[i] = (i < W0) ? a_raw[i] : a_raw[W0-1];
          b_ext[i] = (i < W0) ? b_raw[i] : b_raw[W0-1];
        end
      end
      MODE_16: begin
        mneg = MNEG1;
        for (int i = 0; i < DW; i++) begin
          a_ext[i] = (i < W1) ? a_raw[i] : a_raw[W1-1];
          b_ext[i] = (i < W1) ? b_raw[i] : b_raw[W1-1];
        end
      end
      MODE_32: begin
        mneg = MNEG2;
        for (int i = 0; i < DW; i++) begin
          a_ext[i] = (i < W2) ? a_raw[i] : a_raw[W2-1];
          b_ext[i] = (i < W2) ? b_raw[i] : b_raw[W2-1];
        end
      end
      default: begin
        mneg = MNEG3;
        for (int i = 0; i < DW; i++) begin
          a_ext[i] = (i < W3) ? a_raw[i] : a_raw[W3-1];
          b_ext[i] = (i < W3) ? b_raw[i] : b_raw[W3-1];
        end
      end
    endcase
    a_sgn     = a_ext[DW-1];
    b_sgn     = b_ext[DW-1];
    v_d[0]    = s_axis_tvalid;
    rem_d[0]  = '0;
    num_d[0]  = a_sgn ? (~a_ext + 1'b1) : a_ext;
    den_d[0]  = b_sgn ? (~b_ext + 1'b1) : b_ext;
    neg_d[0]  = a_sgn ^ b_sgn;
    fail_d[0] = (b_ext == '0) || ((a_ext == mneg) && (b_ext == '1));

    // Division stages: one restoring step, one quotient bit each
    for (int k = 0; k < DW; k++) begin
      trial[k]    = {rem_q[k], num_q[k][DW-1]};
      ge[k]       = trial[k] >= {1'b0, den_q[k]};
      v_d[k+1]    = v_q[k];
      rem_d[k+1]  = ge[k] ? DW'(trial[k] - {1'b0, den_q[k]}) : trial[k][DW-1:0];
      num_d[k+1]  = {num_q[k][DW-2:0], ge[k]};
      den_d[k+1]  = den_q[k];
      neg_d[k+1]  = neg_q[k];
      fail_d[k+1] = fail_q[k];
    end
  end

  // Output stage: apply sign, zero on failure, sign-extend to the field width
  always_comb begin
    q_sgn  = neg_q[DW] ? signed'(~num_q[DW] + 1'b1) : signed'(num_q[DW]);
    quot_d = fail_q[DW] ? '0 : OUT_DATA_W'(q_sgn);
    ok_d   = !fail_q[DW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DW; k++) begin
        v_q[k] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (adv) begin
      for (int k = 0; k <= DW; k++) begin
        v_q[k] <= v_d[k];
      end
      out_valid_q <= v_q[DW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k <= DW; k++) begin
        rem_q[k]  <= rem_d[k];
        num_q[k]  <= num_d[k];
        den_q[k]  <= den_d[k];
        neg_q[k]  <= neg_d[k];
        fail_q[k] <= fail_d[k];
      end
      quot_q <= quot_d;
      ok_q   <= ok_d;
    end
  end

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("failed division must give a zero quotient");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[DW] && !fail_q[DW] |-> rem_q[DW] < den_q[DW])
    else $error("final remainder not below divisor");

  a_last_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[DW] && !adv |=> v_q[DW] && $stable(num_q[DW]))
    else $error("last division stage lost its item under stall");

  a_quot_sext: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata == OUT_DATA_W'(signed'(m_axis_tdata[DW-1:0])))
    else $error("quotient not sign-extended from the data width");

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for checked_signed_int_divider at all four operand widths.
// Drives operand pairs from a queue, predicts quotient and ok flag, and checks results in order.
// Depends on csid_pkg and the checked_signed_int_divider RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import csid_pkg::*;

  localparam int unsigned DATA_WIDTH     = 64;
  localparam int unsigned LATENCY        = DATA_WIDTH + 2;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 2000;

  typedef struct packed {
    logic [FIELD_W-1:0] divisor;
    logic [FIELD_W-1:0] dividend;
  } operands_t;

  typedef struct packed {
    logic [FIELD_W-1:0] quotient;
    logic               ok;
  } result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [MODE_W-1:0]     cfg_data_i    = MODE_64;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata  = '0;  // dividend, divisor
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;        // quotient
  logic                  m_axis_tuser;        // ok

  mode_e       width_sel   = MODE_64;
  operands_t   pending_q[$];
  result_t     quotient_q[$];
  result_t     want_res;
  int unsigned mismatches  = 0;
  bit          src_idle_on = 1'b0;
  bit          snk_idle_on = 1'b0;
  int unsigned hold_req    = 0;
  int unsigned hold_seen   = 0;
  int unsigned hold_left   = 0;
  int unsigned src_gap     = 0;
  int unsigned snk_gap     = 0;
  int unsigned stall_cycles = 0;

  checked_signed_int_divider #(
    .DATA_WIDTH(DATA_WIDTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned width_of(mode_e m);
    int unsigned w;
    w = 32'd8 << m;
    return (w > DATA_WIDTH) ? DATA_WIDTH : w;
  endfunction

  function automatic logic [63:0] low_mask(int unsigned w);
    return (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
  endfunction

  function automatic logic [63:0] sign_extend(logic [63:0] x, int unsigned w);
    logic [63:0] mask;
    mask = low_mask(w);
    x = x & mask;
    if (x[w-1]) x = x | ~mask;
    return x;
  endfunction

  function automatic result_t predict_quotient(mode_e m, operands_t op);
    int unsigned w;
    longint      a;
    longint      b;
    result_t     r;
    w = width_of(m);
    a = sign_extend(op.dividend, w);
    b = sign_extend(op.divisor, w);
    r = '0;
    if (b != 0 && !(a == longint'(~64'd0 << (w - 1)) && b == -1)) begin
      r.quotient = sign_extend(64'(a / b), w);
      r.ok       = 1'b1;
    end
    return r;
  endfunction

  // put random junk above the active width
  function automatic logic [63:0] fill_upper(logic [63:0] low, int unsigned w);
    logic [63:0] mask;
    mask = low_mask(w);
    return ({$urandom, $urandom} & ~mask) | (low & mask);
  endfunction

  function automatic logic [63:0] pick_operand(int unsigned w);
    logic [63:0] pat;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: pat = {$urandom, $urandom};
      4, 5: begin
        pat = {$urandom, $urandom} >> $urandom_range(0, 63);
        if ($urandom_range(0, 1)) pat = -pat;
      end
      6:       pat = 64'd1 << (w - 1);
      7:       pat = (64'd1 << (w - 1)) - 64'd1;
      8:       pat = '1;
      default: pat = 64'($urandom_range(0, 2));
    endcase
    return fill_upper(pat, w);
  endfunction

  task automatic queue_pair(logic [63:0] a, logic [63:0] b);
    operands_t op;
    op.dividend = a;
    op.divisor  = b;
    pending_q.push_back(op);
  endtask

  task automatic queue_width_corners();
    int unsigned w;
    logic [63:0] most_neg;
    w        = width_of(width_sel);
    most_neg = 64'd1 << (w - 1);
    queue_pair(fill_upper(most_neg, w), fill_upper('1, w));
    queue_pair(fill_upper(most_neg - 64'd1, w), fill_upper(64'd0, w));
    queue_pair(fill_upper(most_neg, w), fill_upper(64'd1, w));
  endtask

  task automatic run_phase(int unsigned n_rand);
    int unsigned w;
    operands_t   op;
    w = width_of(width_sel);
    for (int unsigned i = 0; i < n_rand; i++) begin
      op.dividend = pick_operand(w);
      op.divisor  = pick_operand(w);
      pending_q.push_back(op);
    end
    while (pending_q.size() != 0 || s_axis_tvalid || quotient_q.size() != 0)
      @(negedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic write_width(mode_e m);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= m;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    width_sel = m;
  endtask

  // operand driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      src_gap = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready)
        quotient_q.push_back(predict_quotient(width_sel, operands_t'(s_axis_tdata)));
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap--;
          s_axis_tvalid <= 1'b0;
        end else if (src_idle_on && $urandom_range(0, 9) == 0) begin
          src_gap = $urandom_range(0, 18);
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() != 0) begin
          s_axis_tdata  <= pending_q.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor and receiver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      snk_gap   = 0;
      hold_left = 0;
      hold_seen = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (quotient_q.size() == 0) begin
          $error("unexpected item: quotient %h ok %b", m_axis_tdata, m_axis_tuser);
          mismatches++;
        end else begin
          want_res = quotient_q.pop_front();
          if (m_axis_tdata !== want_res.quotient) begin
            $error("quotient: expected %h, got %h", want_res.quotient, m_axis_tdata);
            mismatches++;
          end
          if (m_axis_tuser !== want_res.ok) begin
            $error("ok: expected %b, got %b", want_res.ok, m_axis_tuser);
            mismatches++;
          end
        end
      end
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (snk_gap > 0) begin
        snk_gap--;
        m_axis_tready <= 1'b0;
      end else if (snk_idle_on && $urandom_range(0, 9) == 0) begin
        snk_gap = $urandom_range(0, 18);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles == WATCHDOG_LIMIT) begin
      $display("[checked_signed_int_divider] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    src_idle_on = 1'b1;
    snk_idle_on = 1'b0;
    queue_pair(64'h8000_0000_0000_0000, '1);
    queue_pair(64'h8000_0000_0000_0000, 64'd1);
    queue_pair(64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000);
    queue_pair(64'h7fff_ffff_ffff_ffff, '1);
    queue_pair(64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff);
    queue_pair(64'd5, 64'd0);
    queue_pair(64'd0, 64'd0);
    queue_pair(64'd0, -64'sd3);
    queue_pair(64'd7, 64'd2);
    queue_pair(-64'sd7, 64'd2);
    queue_pair(64'd7, -64'sd2);
    queue_pair(-64'sd7, -64'sd2);
    queue_pair(64'd1, 64'h7fff_ffff_ffff_ffff);
    run_phase(200);

    write_width(MODE_8);
    snk_idle_on = 1'b1;
    queue_width_corners();
    run_phase(300);

    write_width(MODE_16);
    src_idle_on = 1'b0;
    hold_req++;
    queue_width_corners();
    run_phase(250);

    write_width(MODE_32);
    src_idle_on = 1'b1;
    queue_width_corners();
    run_phase(250);

    write_width(MODE_64);
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    run_phase(200);

    if (mismatches == 0 && quotient_q.size() == 0) begin
      $display("[checked_signed_int_divider] OK");
    end else begin
      $display("[checked_signed_int_divider] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/csid_pkg.sv
hw/rtl/checked_signed_int_divider.sv
dv/testbench.sv
